// ===== src/ved_pkg.sv =====
// Shared types, character codes and helpers for the vis escape decoder.
package ved_pkg;

    localparam int HELD_DEPTH_DEF = 16;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_F      = 8'h66;

    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_HT  = 8'h09;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_BEL = 8'h07;
    localparam logic [7:0] CTL_VT  = 8'h0B;
    localparam logic [7:0] CTL_FF  = 8'h0C;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_OCT  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        EM_IDLE       = 3'd0,
        EM_FAIL_BS    = 3'd1,
        EM_FAIL_HELD  = 3'd2,
        EM_SINGLE     = 3'd3,
        EM_FLUSH_BS   = 3'd4,
        EM_FLUSH_HELD = 3'd5
    } t_emit_state;

    // What one accepted item has to emit, in order: failed escape, single byte, flush.
    typedef struct packed {
        logic       fail;
        logic       single;
        logic [7:0] single_byte;
        logic       flush;
        logic       last;
    } t_plan;

    // Map the byte after a backslash to its control code; bit 8 flags a match.
    function automatic logic [8:0] ctl_code(logic [7:0] b);
        logic [8:0] r;
        case (b)
            CH_N:      r = {1'b1, CTL_LF};
            CH_R:      r = {1'b1, CTL_CR};
            CH_T:      r = {1'b1, CTL_HT};
            CH_B:      r = {1'b1, CTL_BS};
            CH_A:      r = {1'b1, CTL_BEL};
            CH_V:      r = {1'b1, CTL_VT};
            CH_F:      r = {1'b1, CTL_FF};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/ved_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ved_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// ===== src/ved_step.sv =====
// Escape state machine: classifies each accepted byte and plans its results.
module ved_step #(
    parameter int HELD_DEPTH = ved_pkg::HELD_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_byte,
    input  logic                          i_last,
    output ved_pkg::t_plan                o_plan,
    output logic [$clog2(HELD_DEPTH+1)-1:0] o_fail_cnt,
    output logic [$clog2(HELD_DEPTH+1)-1:0] o_flush_cnt,
    output logic                          o_we,
    output logic [$clog2(HELD_DEPTH)-1:0] o_waddr,
    output logic [7:0]                    o_wdata
);
    localparam int CW = $clog2(HELD_DEPTH + 1);
    localparam int AW = $clog2(HELD_DEPTH);

    ved_pkg::t_phase r_phase, n_phase;
    logic [8:0]      r_val, n_val;
    logic [1:0]      r_dc, n_dc;
    logic [CW-1:0]   r_held, n_held;

    logic            is_oct, is_cr, reproc, hold, hold_first;
    logic [8:0]      ctl;
    logic [2:0]      dig;

    assign is_oct = (i_byte >= ved_pkg::CH_ZERO) && (i_byte <= ved_pkg::CH_SEVEN);
    assign is_cr  = (i_byte == ved_pkg::CH_CR);
    assign ctl    = ved_pkg::ctl_code(i_byte);
    assign dig    = i_byte[2:0];

    always_comb begin
        n_phase     = r_phase;
        n_val       = r_val;
        n_dc        = r_dc;
        n_held      = r_held;
        o_plan      = '0;
        o_fail_cnt  = '0;
        o_flush_cnt = '0;
        reproc      = 1'b0;
        hold        = 1'b0;
        hold_first  = 1'b0;
        case (r_phase)
            ved_pkg::PH_ESC: begin
                if (ctl[8]) begin
                    o_plan.single      = 1'b1;
                    o_plan.single_byte = ctl[7:0];
                    n_phase = ved_pkg::PH_IDLE;
                    n_val   = '0;
                    n_dc    = '0;
                    n_held  = '0;
                end else if (is_oct) begin
                    n_phase    = ved_pkg::PH_OCT;
                    n_held     = CW'(1);
                    hold       = 1'b1;
                    hold_first = 1'b1;
                    n_val      = {6'd0, dig};
                    n_dc       = 2'd1;
                end else begin
                    o_plan.fail = 1'b1;
                    o_fail_cnt  = r_held;
                    n_val       = '0;
                    n_dc        = '0;
                    n_held      = '0;
                    reproc      = 1'b1;
                end
            end
            ved_pkg::PH_OCT: begin
                if (is_oct && (r_dc == 2'd2)) begin
                    // third digit always completes; value truncated to a byte
                    o_plan.single      = 1'b1;
                    o_plan.single_byte = {r_val[4:0], dig};
                    n_phase = ved_pkg::PH_IDLE;
                    n_val   = '0;
                    n_dc    = '0;
                    n_held  = '0;
                end else if ((is_oct || is_cr) && (r_held < CW'(HELD_DEPTH))) begin
                    hold   = 1'b1;
                    n_held = r_held + CW'(1);
                    if (!is_cr) begin
                        n_val = {r_val[5:0], dig};
                        n_dc  = r_dc + 2'd1;
                    end
                end else begin
                    o_plan.fail = 1'b1;
                    o_fail_cnt  = r_held;
                    n_val       = '0;
                    n_dc        = '0;
                    n_held      = '0;
                    reproc      = 1'b1;
                end
            end
            default: begin
                reproc = 1'b1;
            end
        endcase

        // handle the byte as if no escape were open
        if (reproc) begin
            if (i_byte == ved_pkg::CH_BSLASH) begin
                n_phase = ved_pkg::PH_ESC;
            end else begin
                n_phase            = ved_pkg::PH_IDLE;
                o_plan.single      = 1'b1;
                o_plan.single_byte = i_byte;
            end
        end

        // end of buffer: flush any open escape
        if (i_last && (n_phase != ved_pkg::PH_IDLE)) begin
            o_plan.flush = 1'b1;
            o_flush_cnt  = n_held;
            n_phase      = ved_pkg::PH_IDLE;
            n_val        = '0;
            n_dc         = '0;
            n_held       = '0;
        end
        o_plan.last = i_last;
    end

    assign o_we    = i_accept && hold;
    assign o_waddr = hold_first ? '0 : r_held[AW-1:0];
    assign o_wdata = i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ved_pkg::PH_IDLE;
            r_val   <= '0;
            r_dc    <= '0;
            r_held  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_val   <= n_val;
            r_dc    <= n_dc;
            r_held  <= n_held;
        end
    end
endmodule

// ===== src/ved_emit.sv =====
// Result sequencer: walks one item's plan and drives the registered output stage.
module ved_emit #(
    parameter int HELD_DEPTH = ved_pkg::HELD_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  ved_pkg::t_plan                  i_plan,
    input  logic [$clog2(HELD_DEPTH+1)-1:0] i_fail_cnt,
    input  logic [$clog2(HELD_DEPTH+1)-1:0] i_flush_cnt,
    output logic                            o_ready,
    output logic                            o_re,
    output logic [$clog2(HELD_DEPTH)-1:0]   o_raddr,
    input  logic [7:0]                      i_rdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [7:0]                      o_m_tdata,
    output logic                            o_m_tlast,
    output logic                            o_m_tuser
);
    localparam int CW = $clog2(HELD_DEPTH + 1);
    localparam int AW = $clog2(HELD_DEPTH);

    ved_pkg::t_emit_state r_state, n_state, first_st, after_fail;
    ved_pkg::t_plan       r_plan;
    logic [CW-1:0]        r_fail_cnt, r_flush_cnt, r_idx, idx_inc;
    logic                 r_have;
    logic                 free, held_st, emit, final_res;
    logic [7:0]           emit_byte;

    logic                 r_ovalid, r_olast, r_oend;
    logic [7:0]           r_obyte;

    assign free    = !r_ovalid || i_m_tready;
    assign idx_inc = r_idx + CW'(1);

    always_comb begin
        if (i_plan.fail) begin
            first_st = ved_pkg::EM_FAIL_BS;
        end else if (i_plan.single) begin
            first_st = ved_pkg::EM_SINGLE;
        end else if (i_plan.flush) begin
            first_st = ved_pkg::EM_FLUSH_BS;
        end else begin
            first_st = ved_pkg::EM_IDLE;
        end
        if (r_plan.single) begin
            after_fail = ved_pkg::EM_SINGLE;
        end else if (r_plan.flush) begin
            after_fail = ved_pkg::EM_FLUSH_BS;
        end else begin
            after_fail = ved_pkg::EM_IDLE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ved_pkg::EM_IDLE: begin
                if (i_accept) n_state = first_st;
            end
            ved_pkg::EM_FAIL_BS: begin
                if (free) begin
                    n_state = (r_fail_cnt != '0) ? ved_pkg::EM_FAIL_HELD : after_fail;
                end
            end
            ved_pkg::EM_FAIL_HELD: begin
                if (r_have && free && (idx_inc >= r_fail_cnt)) n_state = after_fail;
            end
            ved_pkg::EM_SINGLE: begin
                if (free) begin
                    n_state = r_plan.flush ? ved_pkg::EM_FLUSH_BS : ved_pkg::EM_IDLE;
                end
            end
            ved_pkg::EM_FLUSH_BS: begin
                if (free) begin
                    n_state = (r_flush_cnt != '0) ? ved_pkg::EM_FLUSH_HELD
                                                  : ved_pkg::EM_IDLE;
                end
            end
            ved_pkg::EM_FLUSH_HELD: begin
                if (r_have && free && (idx_inc >= r_flush_cnt)) n_state = ved_pkg::EM_IDLE;
            end
            default: begin
                n_state = ved_pkg::EM_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready   = 1'b0;
        held_st   = 1'b0;
        emit      = 1'b0;
        emit_byte = ved_pkg::CH_BSLASH;
        case (r_state)
            ved_pkg::EM_IDLE: begin
                o_ready = 1'b1;
            end
            ved_pkg::EM_FAIL_BS, ved_pkg::EM_FLUSH_BS: begin
                emit = free;
            end
            ved_pkg::EM_SINGLE: begin
                emit      = free;
                emit_byte = r_plan.single_byte;
            end
            ved_pkg::EM_FAIL_HELD, ved_pkg::EM_FLUSH_HELD: begin
                held_st   = 1'b1;
                emit      = r_have && free;
                emit_byte = i_rdata;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
        final_res = (n_state == ved_pkg::EM_IDLE);
        o_re      = held_st && !r_have;
    end

    assign o_raddr = r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ved_pkg::EM_IDLE;
            r_have   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_re) begin
                r_have <= 1'b1;
            end else if (emit && held_st) begin
                r_have <= 1'b0;
            end
            if (r_state != n_state) begin
                r_idx <= '0;
            end else if (emit && held_st) begin
                r_idx <= idx_inc;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_plan      <= i_plan;
            r_fail_cnt  <= i_fail_cnt;
            r_flush_cnt <= i_flush_cnt;
        end
        if (emit) begin
            r_obyte <= emit_byte;
            r_olast <= final_res;
            r_oend  <= final_res && r_plan.last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_obyte;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_oend;
endmodule

// ===== src/vis_escape_decoder.sv =====
// Top level of the vis escape decoder: byte stream in, decoded byte stream out.
//
// Slave channel (i_s_*): one encoded byte per item, i_s_tlast marks the end of
// the buffer. Master channel (o_m_*): decoded bytes; o_m_tlast marks the last
// result of one input item, o_m_tuser the last result of the whole buffer.
// An input item may cause no result (backslash, held digits) or up to
// HELD_DEPTH + 2 results (failed escape plus flush at end of buffer).
//
// Timing: o_s_tready is high only while the sequencer is idle. An item with
// no result leaves the sequencer idle, ready for the following item. Each
// result is loaded into the output register from its own sequencer state; a
// held byte replayed after a failed escape is first read from the held store,
// which has a registered read port. The sequencer walks one result at a time,
// so it takes a new item only once the last result of the previous one is loaded.
//
// Reset (i_rst_n low, synchronous) closes any open escape and empties the
// output register; held store contents are left as they are. When the
// receiver stalls, the output register holds its item and the sequencer
// waits; a new input item is still taken as soon as the sequencer is idle.
module vis_escape_decoder #(
    parameter int HELD_DEPTH = ved_pkg::HELD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // in_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // run_last
    output logic       o_m_tuser    // [0] buffer_end
);
    localparam int CW = $clog2(HELD_DEPTH + 1);
    localparam int AW = $clog2(HELD_DEPTH);

    logic           accept;
    ved_pkg::t_plan plan;
    logic [CW-1:0]  fail_cnt, flush_cnt;
    logic           we, re;
    logic [AW-1:0]  waddr, raddr;
    logic [7:0]     wdata, rdata;

    // an item enters when the sequencer has finished the previous one
    assign accept = i_s_tvalid && o_s_tready;

    // escape tracking and per-item result plan
    ved_step #(.HELD_DEPTH(HELD_DEPTH)) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_plan      (plan),
        .o_fail_cnt  (fail_cnt),
        .o_flush_cnt (flush_cnt),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata)
    );

    // held digits and carriage returns of the open octal escape
    ved_ram #(.WIDTH(8), .DEPTH(HELD_DEPTH)) u_held (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // replay the plan one result at a time into the output register
    ved_emit #(.HELD_DEPTH(HELD_DEPTH)) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_plan      (plan),
        .i_fail_cnt  (fail_cnt),
        .i_flush_cnt (flush_cnt),
        .o_ready     (o_s_tready),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );
endmodule

// ===== src/ved_checker.sv =====
// Port-level assertions for the vis escape decoder, bound to its top level.
module ved_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast,
    input logic       o_m_tuser
);
    // output stage is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // end of buffer is always the last result of its item
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("buffer end without item end");

    // the last byte of a buffer always yields a result, so the sequencer is busy next
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("ready straight after end of buffer");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("stalled result changed");
endmodule

bind vis_escape_decoder ved_port_checker u_ved_port_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
